// ----- rtl/ycm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ycm_pkg;

   localparam int COEF_FRAC_BITS_DEF = 14;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEEP_LUMA       = 2'd0,
      CSR_KEEP_INPHASE    = 2'd1,
      CSR_KEEP_QUADRATURE = 2'd2
   } csr_index_type;

   // decimal constant with four places -> fixed point, round half up for non-negative input
   function automatic longint qc(input longint ten_thousandths, input int frac_bits);
      return (ten_thousandths * (longint'(1) << frac_bits) + 64'sd5000) / 64'sd10000;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/yiq_component_mask.sv -----
`timescale 1ns / 1ps
`default_nettype none

// YIQ component mask.
// Request channel: start with req_red_in, req_green_in, req_blue_in. An item is
// taken at every rising edge where start is high and busy is low; busy stays
// low, so one pixel can enter on every clock.
// Result channel: rsp_strobe marks one cycle carrying rsp_red_out,
// rsp_green_out and rsp_blue_out. The receiver cannot stall; results come in
// request order, one per item.
// Pipeline: from accept to strobe, the forward matrix registers its products, then
// its sums; the inverse matrix does the same; saturation feeds the output register.
// Throughput: one item per cycle, set by the fully pipelined multiplier array.
// Configuration: csr_write_enable, csr_index, csr_data write the keep_luma,
// keep_inphase and keep_quadrature flags (bit 0 of csr_data); an index past
// the last flag is ignored. Write them only while the pipeline is empty.
// Reset (synchronous, active high) clears the pipeline valid bits and sets
// all three flags to keep.

module yiq_component_mask #(
   parameter int COEF_FRAC_BITS = ycm_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [7:0]                       req_red_in,
   input  wire logic [7:0]                       req_green_in,
   input  wire logic [7:0]                       req_blue_in,
   output logic                                  rsp_strobe,
   output logic [7:0]                            rsp_red_out,
   output logic [7:0]                            rsp_green_out,
   output logic [7:0]                            rsp_blue_out,
   input  wire logic                             csr_write_enable,
   input  wire logic [ycm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ycm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int F      = COEF_FRAC_BITS;
   localparam int CW     = F + 2;
   localparam int PIX_W  = 9;
   localparam int FWD_W  = PIX_W + CW + 2;
   localparam int YIQ_W  = F + 10;
   localparam int INV_W  = YIQ_W + CW + 2;
   localparam int UW     = INV_W - 2 * F;

   logic keep_luma_ff;
   logic keep_inphase_ff;
   logic keep_quadrature_ff;

   logic                    accept;
   logic signed [CW-1:0]    fwd_coef [9];
   logic signed [CW-1:0]    inv_coef [9];
   logic signed [PIX_W-1:0] pix_vec [3];
   logic                    fwd_valid;
   logic signed [FWD_W-1:0] fwd_vec [3];
   logic signed [YIQ_W-1:0] yiq_vec [3];
   logic                    inv_valid;
   logic signed [INV_W-1:0] inv_vec [3];

   logic       rsp_strobe_ff;
   logic [7:0] rsp_chan_ff [3];
   logic [7:0] rsp_chan_in [3];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      fwd_coef[0] = CW'( ycm_pkg::qc(2990, F));
      fwd_coef[1] = CW'( ycm_pkg::qc(5870, F));
      fwd_coef[2] = CW'( ycm_pkg::qc(1140, F));
      fwd_coef[3] = CW'( ycm_pkg::qc(5959, F));
      fwd_coef[4] = CW'(-ycm_pkg::qc(2750, F));
      fwd_coef[5] = CW'(-ycm_pkg::qc(3210, F));
      fwd_coef[6] = CW'( ycm_pkg::qc(2065, F));
      fwd_coef[7] = CW'(-ycm_pkg::qc(4969, F));
      fwd_coef[8] = CW'( ycm_pkg::qc(2904, F));
      inv_coef[0] = CW'(longint'(1) << F);
      inv_coef[1] = CW'( ycm_pkg::qc(9489, F));
      inv_coef[2] = CW'( ycm_pkg::qc(6561, F));
      inv_coef[3] = CW'(longint'(1) << F);
      inv_coef[4] = CW'(-ycm_pkg::qc(2645, F));
      inv_coef[5] = CW'(-ycm_pkg::qc(6847, F));
      inv_coef[6] = CW'(longint'(1) << F);
      inv_coef[7] = CW'(-ycm_pkg::qc(11270, F));
      inv_coef[8] = CW'( ycm_pkg::qc(8050, F));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_luma_ff       <= 1'b1;
         keep_inphase_ff    <= 1'b1;
         keep_quadrature_ff <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ycm_pkg::CSR_KEEP_LUMA:       keep_luma_ff       <= csr_data[0];
            ycm_pkg::CSR_KEEP_INPHASE:    keep_inphase_ff    <= csr_data[0];
            ycm_pkg::CSR_KEEP_QUADRATURE: keep_quadrature_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign pix_vec[0] = {1'b0, req_red_in};
   assign pix_vec[1] = {1'b0, req_green_in};
   assign pix_vec[2] = {1'b0, req_blue_in};

   ycm_mat3 #(
      .IN_W   (PIX_W),
      .COEF_W (CW)
   ) u_fwd (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (accept),
      .vec_in    (pix_vec),
      .coef      (fwd_coef),
      .valid_out (fwd_valid),
      .vec_out   (fwd_vec)
   );

   // Y, I, Q magnitudes stay well below 2^(F+9)
   assign yiq_vec[0] = keep_luma_ff       ? YIQ_W'(fwd_vec[0]) : '0;
   assign yiq_vec[1] = keep_inphase_ff    ? YIQ_W'(fwd_vec[1]) : '0;
   assign yiq_vec[2] = keep_quadrature_ff ? YIQ_W'(fwd_vec[2]) : '0;

   ycm_mat3 #(
      .IN_W   (YIQ_W),
      .COEF_W (CW)
   ) u_inv (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (fwd_valid),
      .vec_in    (yiq_vec),
      .coef      (inv_coef),
      .valid_out (inv_valid),
      .vec_out   (inv_vec)
   );

   // negative sums truncate to <= 0 and saturate to 0
   always_comb begin
      logic [UW-1:0] upper;
      for (int c = 0; c < 3; c++) begin
         upper = inv_vec[c][INV_W-1:2*F];
         if (upper[UW-1]) begin
            rsp_chan_in[c] = 8'd0;
         end else if (|upper[UW-2:8]) begin
            rsp_chan_in[c] = 8'd255;
         end else begin
            rsp_chan_in[c] = upper[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= inv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_chan_ff <= rsp_chan_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_red_out   = rsp_chan_ff[0];
   assign rsp_green_out = rsp_chan_ff[1];
   assign rsp_blue_out  = rsp_chan_ff[2];

   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_strobe)
      else $error("accepted item produced no result after five cycles");

   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 5))
      else $error("result without a matching item");

   a_fwd_from_accept: assert property (@(posedge clock) disable iff (reset)
      fwd_valid |-> $past(accept, 2))
      else $error("forward stage valid out of step with input");

endmodule

`default_nettype wire

// ----- rtl/ycm_mat3.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ycm_mat3 #(
   parameter int IN_W   = 9,
   parameter int COEF_W = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           valid_in,
   input  wire logic signed [IN_W-1:0]         vec_in [3],
   input  wire logic signed [COEF_W-1:0]       coef [9],
   output logic                                valid_out,
   output logic signed [IN_W+COEF_W+1:0]       vec_out [3]
);

   localparam int PW = IN_W + COEF_W;
   localparam int SW = PW + 2;

   logic                 prod_valid_ff;
   logic signed [PW-1:0] prod_ff [9];
   logic signed [PW-1:0] prod_in [9];
   logic                 sum_valid_ff;
   logic signed [SW-1:0] sum_ff [3];
   logic signed [SW-1:0] sum_in [3];

   // stage 1: nine products, row r column c at 3*r+c
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[3*r+c] = PW'(vec_in[c]) * PW'(coef[3*r+c]);
         end
      end
   end

   // stage 2: row sums
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SW'(prod_ff[3*r]) + SW'(prod_ff[3*r+1]) + SW'(prod_ff[3*r+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= valid_in;
         sum_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign valid_out = sum_valid_ff;
   assign vec_out   = sum_ff;

endmodule

`default_nettype wire
